@@ design/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIDA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sida assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SIDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sida assertion failed");

`endif

@@ design/sida_pkg.sv @@
// Shared types, constants and helpers of the decimal ASCII converter.
`timescale 1ns / 1ps
package sida_pkg;

  localparam int unsigned MagW      = 16;
  localparam int unsigned CharW     = 8;
  localparam int unsigned NumDigits = 5;
  localparam int unsigned PosW      = 3;
  localparam int unsigned PowW      = 17;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW     = 1;
  localparam int unsigned QCntW     = 2;

  localparam logic [CharW-1:0]  CharZero  = 8'd48;
  localparam logic [CharW-1:0]  CharMinus = 8'd45;
  localparam logic [PosW-1:0]   PosLast   = 3'd4;
  localparam logic [MagW-1:0]   SignMask  = 16'h8000;

  // One classified request: sign flag and magnitude.
  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] mag;
  } entry_t;

  // Status of the queue as seen by the back end.
  typedef struct packed {
    logic   empty;
    entry_t head;
  } queue_stat_t;

  typedef enum logic [1:0] {
    BackIdle,
    BackSign,
    BackDigit
  } back_state_e;

  // Weight of a decimal position, most significant position first.
  function automatic logic [PowW-1:0] pos_weight(input logic [PosW-1:0] pos);
    logic [PowW-1:0] w;
    case (pos)
      3'd0:    w = 17'd10000;
      3'd1:    w = 17'd1000;
      3'd2:    w = 17'd100;
      3'd3:    w = 17'd10;
      default: w = 17'd1;
    endcase
    return w;
  endfunction

endpackage

@@ design/sida_queue.sv @@
// Two-entry queue between the classifying front end and the digit back end.
`timescale 1ns / 1ps
module sida_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  sida_pkg::entry_t      wr_data_i,
  input  logic                  rd_en_i,
  output logic                  full_o,
  output sida_pkg::queue_stat_t stat_o
);

  sida_pkg::entry_t mem_q [sida_pkg::QueueDepth];

  logic [sida_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [sida_pkg::QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [sida_pkg::QCntW-1:0] cnt_q, cnt_d;
  logic                       do_wr, do_rd;

  assign full_o       = (cnt_q == sida_pkg::QCntW'(sida_pkg::QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.head  = mem_q[rd_ptr_q];

  assign do_wr = wr_en_i && !full_o;
  assign do_rd = rd_en_i && !stat_o.empty;

  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ design/sida_front.sv @@
// Front end: accepts a raw word and splits it into sign and magnitude.
`timescale 1ns / 1ps
module sida_front (
  input  logic                          push_i,
  input  logic [sida_pkg::MagW-1:0]     value_i,
  input  logic                          q_full_i,
  output logic                          wr_en_o,
  output sida_pkg::entry_t              entry_o
);

  logic neg;

  assign neg     = (value_i & sida_pkg::SignMask) != '0;
  assign wr_en_o = push_i && !q_full_i;

  // The most negative word negates to itself, which is its true magnitude.
  assign entry_o.neg = neg;
  assign entry_o.mag = neg ? (~value_i + 1'b1) : value_i;

endmodule

@@ design/sida_back.sv @@
// Back end: walks the five decimal positions and emits at most one character per step.
`timescale 1ns / 1ps
module sida_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sida_pkg::queue_stat_t         stat_i,
  output logic                          q_rd_o,
  input  logic                          pop_i,
  output logic                          empty_o,
  output logic [sida_pkg::CharW-1:0]    ascii_char_o,
  output logic                          last_o
);

  sida_pkg::back_state_e state_q, state_d;

  logic [sida_pkg::PosW-1:0]  pos_q;
  logic [sida_pkg::MagW-1:0]  rem_q, rem_next;
  logic                       started_q;
  logic                       out_valid_q;
  logic [sida_pkg::CharW-1:0] out_char_q;
  logic                       out_last_q;

  logic                       adv;
  logic                       load;
  logic                       emit;
  logic                       step;
  logic                       pos_end;
  logic [sida_pkg::CharW-1:0] emit_char;
  logic                       emit_last;
  logic [sida_pkg::PowW-1:0]  weight;
  logic [9:1]                 ge;
  logic [sida_pkg::PowW-1:0]  sub_val;
  logic [3:0]                 digit;

  // The output slot can take a new character when it is free or being drained.
  assign adv     = !out_valid_q || pop_i;
  assign pos_end = (pos_q == sida_pkg::PosLast);

  // Digit at the current position: count of weight multiples not above the remainder.
  always_comb begin
    weight  = sida_pkg::pos_weight(pos_q);
    sub_val = '0;
    for (int k = 1; k <= 9; k++) begin
      ge[k] = {1'b0, rem_q} >= sida_pkg::PowW'(weight * sida_pkg::PowW'(k));
      if (ge[k]) begin
        sub_val = sida_pkg::PowW'(weight * sida_pkg::PowW'(k));
      end
    end
    digit    = 4'($countones(ge));
    rem_next = rem_q - sub_val[sida_pkg::MagW-1:0];
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sida_pkg::BackIdle: begin
        if (!stat_i.empty) begin
          state_d = stat_i.head.neg ? sida_pkg::BackSign : sida_pkg::BackDigit;
        end
      end
      sida_pkg::BackSign: begin
        if (adv) begin
          state_d = sida_pkg::BackDigit;
        end
      end
      sida_pkg::BackDigit: begin
        if (adv && pos_end) begin
          if (!stat_i.empty) begin
            state_d = stat_i.head.neg ? sida_pkg::BackSign : sida_pkg::BackDigit;
          end else begin
            state_d = sida_pkg::BackIdle;
          end
        end
      end
      default: state_d = sida_pkg::BackIdle;
    endcase
  end

  // Output logic.
  always_comb begin
    load      = 1'b0;
    emit      = 1'b0;
    step      = 1'b0;
    emit_char = sida_pkg::CharZero + sida_pkg::CharW'(digit);
    emit_last = pos_end;
    case (state_q)
      sida_pkg::BackIdle: begin
        load = !stat_i.empty;
      end
      sida_pkg::BackSign: begin
        emit      = adv;
        emit_char = sida_pkg::CharMinus;
        emit_last = 1'b0;
      end
      sida_pkg::BackDigit: begin
        step = adv;
        // Leading zeros are dropped, but the units digit always prints.
        emit = adv && (started_q || (digit != '0) || pos_end);
        load = adv && pos_end && !stat_i.empty;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  assign q_rd_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sida_pkg::BackIdle;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        pos_q <= '0;
      end else if (step) begin
        pos_q <= pos_q + 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q     <= stat_i.head.mag;
      started_q <= 1'b0;
    end else if (step) begin
      rem_q     <= rem_next;
      started_q <= started_q || (digit != '0);
    end
    if (emit) begin
      out_char_q <= emit_char;
      out_last_q <= emit_last;
    end
  end

  assign empty_o      = !out_valid_q;
  assign ascii_char_o = out_char_q;
  assign last_o       = out_last_q;

endmodule

@@ design/signed_int_to_decimal_ascii.sv @@
// An accepted request is registered in the queue, then loaded by the back end, whose
// characters are held in the output register. The back sequencer visits the five
// decimal positions one per cycle while its output slot is free or being drained.
// Up to two classified values wait in the queue while the back end is busy.
// Reset (rst_ni low, asynchronous) empties the queue and the output register.
`timescale 1ns / 1ps
module signed_int_to_decimal_ascii (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [sida_pkg::MagW-1:0]     value_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [sida_pkg::CharW-1:0]    ascii_char_o,
  output logic                          last_o
);

  logic                  q_wr;
  logic                  q_rd;
  sida_pkg::entry_t      q_entry;
  sida_pkg::queue_stat_t q_stat;

  sida_front u_front (
    .push_i   (push),
    .value_i  (value_i),
    .q_full_i (full),
    .wr_en_o  (q_wr),
    .entry_o  (q_entry)
  );

  sida_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (q_wr),
    .wr_data_i (q_entry),
    .rd_en_i   (q_rd),
    .full_o    (full),
    .stat_o    (q_stat)
  );

  sida_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stat_i       (q_stat),
    .q_rd_o       (q_rd),
    .pop_i        (pop),
    .empty_o      (empty),
    .ascii_char_o (ascii_char_o),
    .last_o       (last_o)
  );

endmodule

@@ design/sida_checker.sv @@
// Port-level checker for the decimal ASCII converter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sida_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       push,
  input logic                       full,
  input logic [sida_pkg::MagW-1:0]  value_i,
  input logic                       empty,
  input logic                       pop,
  input logic [sida_pkg::CharW-1:0] ascii_char_o,
  input logic                       last_o
);

  logic                     is_minus;
  logic                     is_digit;
  logic                     is_zero;
  logic [sida_pkg::CharW:0] out_word;

  assign is_minus = (ascii_char_o == sida_pkg::CharMinus);
  assign is_digit = (ascii_char_o >= sida_pkg::CharZero) &&
                    (ascii_char_o <= sida_pkg::CharZero + 8'd9);
  assign is_zero  = (ascii_char_o == sida_pkg::CharZero);
  assign out_word = {last_o, ascii_char_o};

  // A waiting result that is not taken stays put.
  `SIDA_ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_word))

  // Every character shown is a minus sign or a decimal digit.
  `SIDA_ASSERT_IMPL(a_charset, clk_i, rst_ni, !empty, is_minus || is_digit)

  // A run never ends on its sign.
  `SIDA_ASSERT_IMPL(a_sign_not_last, clk_i, rst_ni, !empty && is_minus, !last_o)

  // A sign is followed by a nonzero leading digit.
  `SIDA_ASSERT_NEXT(a_no_lead_zero, clk_i, rst_ni, !empty && pop && is_minus, empty || !is_zero)

  // An accepted request carries a fully known word.
  `SIDA_ASSERT_IMPL(a_push_known, clk_i, rst_ni, push && !full, !$isunknown(value_i))

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .push         (push),
  .full         (full),
  .value_i      (value_i),
  .empty        (empty),
  .pop          (pop),
  .ascii_char_o (ascii_char_o),
  .last_o       (last_o)
);
